@@ sv/tcce_pkg.sv @@
// Package for the text console cursor engine: payload structs, codes,
// controller states, command and status structs, and helper functions.
// No dependencies; every other file of the block imports it.
package tcce_pkg;

   localparam int COL_LIMIT = 256;
   localparam int ROW_LIMIT = 256;
   localparam int GRID_CAP = 256;
   localparam int COL_MAX_I = (COL_LIMIT < GRID_CAP) ? COL_LIMIT : GRID_CAP;
   localparam int ROW_MAX_I = (ROW_LIMIT < GRID_CAP) ? ROW_LIMIT : GRID_CAP;
   localparam logic [8:0] COL_MAX = 9'(COL_MAX_I);
   localparam logic [8:0] ROW_MAX = 9'(ROW_MAX_I);

   localparam logic [8:0] COLUMNS_RESET = 9'd80;
   localparam logic [8:0] ROWS_RESET = 9'd25;

   localparam int TAB_PITCH = 4;
   localparam int CLEAR_LEN = 7;

   localparam logic [1:0] CSR_COLUMNS = 2'd0;
   localparam logic [1:0] CSR_ROWS = 2'd1;

   localparam logic [1:0] KIND_DRAW = 2'd0;
   localparam logic [1:0] KIND_SCROLL = 2'd1;
   localparam logic [1:0] KIND_SERIAL = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;

   localparam logic MODE_CLEAR = 1'b1;

   localparam logic [7:0] CHAR_BS = 8'h08;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_ESC = 8'h1B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TWO = 8'h32;
   localparam logic [7:0] CHAR_H = 8'h48;
   localparam logic [7:0] CHAR_J = 8'h4A;
   localparam logic [7:0] CHAR_BRACKET = 8'h5B;

   typedef struct packed {
      logic       mode;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] cell_col;
      logic [7:0] cell_row;
      logic [7:0] code;
      logic       last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_CLR_SEQ,
      ST_CR,
      ST_LF_SCROLL,
      ST_LF_CR,
      ST_LF_LF,
      ST_BS_DRAW,
      ST_BS_B1,
      ST_BS_SP,
      ST_BS_B2,
      ST_PR_DRAW,
      ST_PR_SERIAL,
      ST_PR_SCROLL
   } state_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_HOME,
      CUR_COL_ZERO,
      CUR_COL_DEC,
      CUR_NEXT_LINE,
      CUR_ROW_LAST,
      CUR_ADVANCE
   } cur_op_type;

   typedef enum logic [3:0] {
      EM_NONE,
      EM_CLEAR,
      EM_SEQ,
      EM_SERIAL_CR,
      EM_SERIAL_LF,
      EM_SERIAL_BS,
      EM_SERIAL_SP,
      EM_SERIAL_CODE,
      EM_DRAW_CUR,
      EM_DRAW_BLANK,
      EM_SCROLL
   } emit_type;

   typedef struct packed {
      logic       emit;
      emit_type   sel;
      logic       last;
      cur_op_type cur;
      logic       latch;
      logic       cnt_clr;
      logic       cnt_inc;
   } cmd_type;

   typedef struct packed {
      logic is_clear;
      logic is_cr;
      logic is_lf;
      logic is_bs;
      logic is_tab;
      logic col_zero;
      logic tab_ok;
      logic lf_scroll;
      logic wrap;
      logic more_tab;
      logic tab_item;
      logic seq_end;
      logic out_free;
   } status_type;

   function automatic logic [8:0] grid_size(input logic [8:0] value, input logic [8:0] limit);
      logic [8:0] size;
      size = value;
      if (size == 9'd0) begin
         size = 9'd1;
      end
      if (size > limit) begin
         size = limit;
      end
      return size;
   endfunction

   function automatic logic [7:0] clear_byte(input logic [2:0] idx);
      logic [7:0] byte_val;
      case (idx)
         3'd0: byte_val = CHAR_ESC;
         3'd1: byte_val = CHAR_BRACKET;
         3'd2: byte_val = CHAR_TWO;
         3'd3: byte_val = CHAR_J;
         3'd4: byte_val = CHAR_ESC;
         3'd5: byte_val = CHAR_BRACKET;
         3'd6: byte_val = CHAR_H;
         default: byte_val = 8'h00;
      endcase
      return byte_val;
   endfunction

endpackage

@@ sv/tcce_ctrl.sv @@
// Controller state machine of the text console cursor engine.
// Turns datapath status into commands; depends on tcce_pkg.
module tcce_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tcce_pkg::status_type status,
   output tcce_pkg::cmd_type    cmd
);
   import tcce_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;
   logic      advance;
   logic      is_other;

   assign accept = (state_ff == ST_IDLE) && req_valid;
   assign advance = (state_ff != ST_IDLE) && status.out_free;
   assign is_other = !status.is_clear && !status.is_cr && !status.is_lf &&
                     !status.is_bs && !status.is_tab;
   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.is_clear) begin
                  state_in = ST_CLEAR;
               end else if (status.is_cr) begin
                  state_in = ST_CR;
               end else if (status.is_lf) begin
                  state_in = status.lf_scroll ? ST_LF_SCROLL : ST_LF_CR;
               end else if (status.is_bs) begin
                  if (!status.col_zero) begin
                     state_in = ST_BS_DRAW;
                  end
               end else if (status.is_tab) begin
                  if (status.tab_ok) begin
                     state_in = ST_PR_DRAW;
                  end
               end else if (is_other) begin
                  state_in = ST_PR_DRAW;
               end
            end
         end
         ST_CLEAR: if (advance) state_in = ST_CLR_SEQ;
         ST_CLR_SEQ: if (advance && status.seq_end) state_in = ST_IDLE;
         ST_CR: if (advance) state_in = ST_IDLE;
         ST_LF_SCROLL: if (advance) state_in = ST_LF_CR;
         ST_LF_CR: if (advance) state_in = ST_LF_LF;
         ST_LF_LF: if (advance) state_in = ST_IDLE;
         ST_BS_DRAW: if (advance) state_in = ST_BS_B1;
         ST_BS_B1: if (advance) state_in = ST_BS_SP;
         ST_BS_SP: if (advance) state_in = ST_BS_B2;
         ST_BS_B2: if (advance) state_in = ST_IDLE;
         ST_PR_DRAW: if (advance) state_in = ST_PR_SERIAL;
         ST_PR_SERIAL: begin
            if (advance) begin
               if (status.wrap) begin
                  state_in = status.lf_scroll ? ST_PR_SCROLL : ST_IDLE;
               end else if (status.tab_item && status.more_tab) begin
                  state_in = ST_PR_DRAW;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PR_SCROLL: if (advance) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               if (status.is_clear) begin
                  cmd.cur = CUR_HOME;
                  cmd.cnt_clr = 1'b1;
               end else if (status.is_cr) begin
                  cmd.cur = CUR_COL_ZERO;
               end else if (status.is_lf) begin
                  cmd.cur = status.lf_scroll ? CUR_COL_ZERO : CUR_NEXT_LINE;
               end else if (status.is_bs && !status.col_zero) begin
                  cmd.cur = CUR_COL_DEC;
               end
            end
         end
         ST_CLEAR: begin
            cmd.emit = advance;
            cmd.sel = EM_CLEAR;
         end
         ST_CLR_SEQ: begin
            cmd.emit = advance;
            cmd.sel = EM_SEQ;
            cmd.cnt_inc = advance;
            cmd.last = status.seq_end;
         end
         ST_CR: begin
            cmd.emit = advance;
            cmd.sel = EM_SERIAL_CR;
            cmd.last = 1'b1;
         end
         ST_LF_SCROLL: begin
            cmd.emit = advance;
            cmd.sel = EM_SCROLL;
            if (advance) cmd.cur = CUR_ROW_LAST;
         end
         ST_LF_CR: begin
            cmd.emit = advance;
            cmd.sel = EM_SERIAL_CR;
         end
         ST_LF_LF: begin
            cmd.emit = advance;
            cmd.sel = EM_SERIAL_LF;
            cmd.last = 1'b1;
         end
         ST_BS_DRAW: begin
            cmd.emit = advance;
            cmd.sel = EM_DRAW_BLANK;
         end
         ST_BS_B1: begin
            cmd.emit = advance;
            cmd.sel = EM_SERIAL_BS;
         end
         ST_BS_SP: begin
            cmd.emit = advance;
            cmd.sel = EM_SERIAL_SP;
         end
         ST_BS_B2: begin
            cmd.emit = advance;
            cmd.sel = EM_SERIAL_BS;
            cmd.last = 1'b1;
         end
         ST_PR_DRAW: begin
            cmd.emit = advance;
            cmd.sel = EM_DRAW_CUR;
         end
         ST_PR_SERIAL: begin
            cmd.emit = advance;
            cmd.sel = EM_SERIAL_CODE;
            if (status.wrap) begin
               cmd.last = !status.lf_scroll;
               if (advance) cmd.cur = status.lf_scroll ? CUR_COL_ZERO : CUR_NEXT_LINE;
            end else begin
               cmd.last = !(status.tab_item && status.more_tab);
               if (advance) cmd.cur = CUR_ADVANCE;
            end
         end
         ST_PR_SCROLL: begin
            cmd.emit = advance;
            cmd.sel = EM_SCROLL;
            cmd.last = 1'b1;
            if (advance) cmd.cur = CUR_ROW_LAST;
         end
         default: cmd = '0;
      endcase
   end

endmodule

@@ sv/tcce_datapath.sv @@
// Datapath of the text console cursor engine: grid registers, cursor,
// latched character, clear sequence counter and the result register.
// Depends on tcce_pkg; driven by tcce_ctrl through cmd_type commands.
module tcce_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  tcce_pkg::cmd_type    cmd,
   output tcce_pkg::status_type status,
   input  tcce_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tcce_pkg::rsp_type    rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [8:0]           csr_wdata
);
   import tcce_pkg::*;

   logic [8:0] columns_ff, columns_in;
   logic [8:0] rows_ff, rows_in;
   logic [7:0] col_ff, col_in;
   logic [7:0] row_ff, row_in;
   logic [7:0] code_ff, code_in;
   logic [8:0] stop_ff, stop_in;
   logic       tab_ff, tab_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic [8:0] ncols;
   logic [8:0] nrows;
   logic [8:0] col_ext;
   logic [8:0] col1;
   logic [8:0] row1;
   logic [8:0] stop_new;
   logic       mode_char;

   assign ncols = grid_size(columns_ff, COL_MAX);
   assign nrows = grid_size(rows_ff, ROW_MAX);
   assign col_ext = {1'b0, col_ff};
   assign col1 = col_ext + 9'd1;
   assign row1 = {1'b0, row_ff} + 9'd1;
   assign stop_new = (col_ext + 9'(TAB_PITCH)) & ~(9'(TAB_PITCH) - 9'd1);
   assign mode_char = (req_data.mode != MODE_CLEAR);

   always_comb begin
      status.is_clear = (req_data.mode == MODE_CLEAR);
      status.is_cr = mode_char && (req_data.char_code == CHAR_CR);
      status.is_lf = mode_char && (req_data.char_code == CHAR_LF);
      status.is_bs = mode_char && (req_data.char_code == CHAR_BS);
      status.is_tab = mode_char && (req_data.char_code == CHAR_TAB);
      status.col_zero = (col_ff == 8'd0);
      status.tab_ok = (col_ext < stop_new) && (col_ext < ncols);
      status.lf_scroll = (row1 >= nrows);
      status.wrap = (col1 >= ncols);
      status.more_tab = (col1 < stop_ff);
      status.tab_item = tab_ff;
      status.seq_end = (cnt_ff == 3'(CLEAR_LEN - 1));
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      columns_in = columns_ff;
      rows_in = rows_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_COLUMNS: columns_in = csr_wdata;
            CSR_ROWS: rows_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      case (cmd.cur)
         CUR_HOLD: ;
         CUR_HOME: begin
            col_in = 8'd0;
            row_in = 8'd0;
         end
         CUR_COL_ZERO: col_in = 8'd0;
         CUR_COL_DEC: col_in = col_ff - 8'd1;
         CUR_NEXT_LINE: begin
            col_in = 8'd0;
            row_in = row1[7:0];
         end
         CUR_ROW_LAST: row_in = 8'(nrows - 9'd1);
         CUR_ADVANCE: col_in = col1[7:0];
         default: ;
      endcase
   end

   always_comb begin
      code_in = code_ff;
      stop_in = stop_ff;
      tab_in = tab_ff;
      if (cmd.latch) begin
         code_in = status.is_tab ? CHAR_SPACE : req_data.char_code;
         stop_in = stop_new;
         tab_in = status.is_tab;
      end
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = 3'd0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 3'd1;
      end
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in.last = cmd.last;
      case (cmd.sel)
         EM_NONE: ;
         EM_CLEAR: rsp_data_in.kind = KIND_CLEAR;
         EM_SEQ: begin
            rsp_data_in.kind = KIND_SERIAL;
            rsp_data_in.code = clear_byte(cnt_ff);
         end
         EM_SERIAL_CR: begin
            rsp_data_in.kind = KIND_SERIAL;
            rsp_data_in.code = CHAR_CR;
         end
         EM_SERIAL_LF: begin
            rsp_data_in.kind = KIND_SERIAL;
            rsp_data_in.code = CHAR_LF;
         end
         EM_SERIAL_BS: begin
            rsp_data_in.kind = KIND_SERIAL;
            rsp_data_in.code = CHAR_BS;
         end
         EM_SERIAL_SP: begin
            rsp_data_in.kind = KIND_SERIAL;
            rsp_data_in.code = CHAR_SPACE;
         end
         EM_SERIAL_CODE: begin
            rsp_data_in.kind = KIND_SERIAL;
            rsp_data_in.code = code_ff;
         end
         EM_DRAW_CUR: begin
            rsp_data_in.kind = KIND_DRAW;
            rsp_data_in.cell_col = col_ff;
            rsp_data_in.cell_row = row_ff;
            rsp_data_in.code = code_ff;
         end
         EM_DRAW_BLANK: begin
            rsp_data_in.kind = KIND_DRAW;
            rsp_data_in.cell_col = col_ff;
            rsp_data_in.cell_row = row_ff;
            rsp_data_in.code = CHAR_SPACE;
         end
         EM_SCROLL: rsp_data_in.kind = KIND_SCROLL;
         default: ;
      endcase
      if (!cmd.emit) begin
         rsp_data_in = rsp_data_ff;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
         rows_ff <= ROWS_RESET;
         col_ff <= 8'd0;
         row_ff <= 8'd0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= 3'd0;
         tab_ff <= 1'b0;
      end else begin
         columns_ff <= columns_in;
         rows_ff <= rows_in;
         col_ff <= col_in;
         row_ff <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
         tab_ff <= tab_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      stop_ff <= stop_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

@@ sv/text_console_cursor_engine_unit.sv @@
// Top level of the text console cursor engine: controller plus datapath.
// Depends on tcce_pkg, tcce_ctrl and tcce_datapath.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid/req_ready    req_type: mode, char_code
//   rsp_     out        rsp_valid/rsp_ready    rsp_type: kind, cell, code, last
//   csr_     in         csr_valid/csr_ready    csr_index, csr_wdata (9 bits)
//
// A request is accepted in the idle state and then emits its results in order:
// two or three results for a printed byte, up to nine for a tab, eight for a clear.
// Results leave one per cycle, unless rsp_ready stalls, through a single output
// register, which is the limiting unit; the next request is taken as soon as the
// last result is in that register. Requests that cause no result keep it idle.
// Synchronous reset homes the cursor and loads an 80 by 25 grid.
// A stalled rsp_ready holds the current result and stops the sequencer.
module text_console_cursor_engine_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcce_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcce_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [8:0]        csr_wdata
);
   import tcce_pkg::*;

   cmd_type    cmd;
   status_type status;

   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcce_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

@@ sv/tcce_checker.sv @@
// Port-level checker for the text console cursor engine, bound to the top.
// Depends on tcce_pkg and text_console_cursor_engine_unit.
module tcce_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input tcce_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tcce_pkg::rsp_type rsp_data
);
   import tcce_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Result changed or dropped while stalled.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.mode == MODE_CLEAR) |=> !req_ready)
      else $error("Clear request did not start its result run.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_CLEAR) |-> !rsp_data.last)
      else $error("Clear command marked as the final result.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.kind == KIND_SCROLL) || (rsp_data.kind == KIND_CLEAR)) |->
      (rsp_data.cell_col == 8'd0) && (rsp_data.cell_row == 8'd0) && (rsp_data.code == 8'd0))
      else $error("Scroll or clear command carries nonzero fields.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_SERIAL) |->
      (rsp_data.cell_col == 8'd0) && (rsp_data.cell_row == 8'd0))
      else $error("Serial byte carries a cell position.");

endmodule

bind text_console_cursor_engine_unit tcce_checker u_tcce_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
